/* rtl/core/ecf_pkg.sv */
// Shared types, constants and the microcode table of the Ethernet command framer.
// Holds the CRC-16 byte update and the control word layout; no dependencies.
`timescale 1ns / 1ps

package ecf_pkg;

	localparam int unsigned LEN_W      = 16;
	localparam int unsigned MAC_W      = 48;
	localparam int unsigned MINSZ_W    = 6;
	localparam int unsigned STEP_W     = 5;
	localparam logic [15:0] CRC_INIT   = 16'h1D0F;
	localparam logic [15:0] CRC_POLY   = 16'h1021;
	localparam logic [5:0]  PAD_CAP    = 6'd46;
	localparam logic [5:0]  INNER_OVHD = 6'd10;

	// Item kinds on the input channel.
	localparam logic MODE_HEADER  = 1'b0;
	localparam logic MODE_PAYLOAD = 1'b1;

	typedef logic [STEP_W-1:0] step_t;

	localparam step_t STEP_HOME    = 5'd0;
	localparam step_t STEP_HDR     = 5'd1;
	localparam step_t STEP_TRAILER = 5'd23;
	localparam step_t STEP_PAD     = 5'd25;

	typedef enum logic [1:0] {
		REG_DEST_MAC  = 2'd0,
		REG_SRC_MAC   = 2'd1,
		REG_START     = 2'd2,
		REG_MIN_BYTES = 2'd3
	} reg_idx_t;

	typedef enum logic [3:0] {
		SRC_ZERO  = 4'd0,
		SRC_DEST  = 4'd1,
		SRC_SRC   = 4'd2,
		SRC_INNER = 4'd3,
		SRC_START = 4'd4,
		SRC_ID    = 4'd5,
		SRC_LEN   = 4'd6,
		SRC_DATA  = 4'd7,
		SRC_CRC   = 4'd8
	} src_t;

	typedef enum logic [1:0] {
		LAST_NO  = 2'd0,
		LAST_CRC = 2'd1,
		LAST_PAD = 2'd2
	} last_t;

	typedef enum logic [2:0] {
		COND_ALWAYS   = 3'd0,
		COND_DISPATCH = 3'd1,
		COND_LEFT_NZ  = 3'd2,
		COND_PAD_ZERO = 3'd3,
		COND_PAD_MORE = 3'd4
	} cond_t;

	typedef struct packed {
		logic       emit;
		src_t       src;
		logic [2:0] sel;
		logic       crc_en;
		last_t      last;
		logic       close;
		cond_t      cond;
		step_t      tgt_t;
		step_t      tgt_f;
	} ctrl_t;

	// Status from the datapath that the sequencer branches on.
	typedef struct packed {
		logic hdr;
		logic pay_end;
		logic left_nz;
		logic pad_zero;
		logic pad_more;
	} seq_stat_t;

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] x;
		x = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (x[15]) begin
				x = {x[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				x = {x[14:0], 1'b0};
			end
		end
		return x;
	endfunction

	function automatic ctrl_t mk(input logic emit, input src_t src, input logic [2:0] sel,
			input logic crc_en, input last_t last, input logic close, input cond_t cond,
			input step_t tgt_t, input step_t tgt_f);
		ctrl_t c;
		c.emit   = emit;
		c.src    = src;
		c.sel    = sel;
		c.crc_en = crc_en;
		c.last   = last;
		c.close  = close;
		c.cond   = cond;
		c.tgt_t  = tgt_t;
		c.tgt_f  = tgt_f;
		return c;
	endfunction

	// Microprogram: step 0 waits for an item; the header runs from step 1,
	// the trailer from step 23 and the padding loop sits at step 25.
	function automatic ctrl_t ucode(input step_t step);
		ctrl_t c;
		unique case (step)
			5'd0:  c = mk(1'b1, SRC_DATA,  3'd0, 1'b1, LAST_NO,  1'b0, COND_DISPATCH,
				STEP_HDR, STEP_HOME);
			5'd1:  c = mk(1'b1, SRC_DEST,  3'd5, 1'b0, LAST_NO,  1'b0, COND_ALWAYS, 5'd2, 5'd2);
			5'd2:  c = mk(1'b1, SRC_DEST,  3'd4, 1'b0, LAST_NO,  1'b0, COND_ALWAYS, 5'd3, 5'd3);
			5'd3:  c = mk(1'b1, SRC_DEST,  3'd3, 1'b0, LAST_NO,  1'b0, COND_ALWAYS, 5'd4, 5'd4);
			5'd4:  c = mk(1'b1, SRC_DEST,  3'd2, 1'b0, LAST_NO,  1'b0, COND_ALWAYS, 5'd5, 5'd5);
			5'd5:  c = mk(1'b1, SRC_DEST,  3'd1, 1'b0, LAST_NO,  1'b0, COND_ALWAYS, 5'd6, 5'd6);
			5'd6:  c = mk(1'b1, SRC_DEST,  3'd0, 1'b0, LAST_NO,  1'b0, COND_ALWAYS, 5'd7, 5'd7);
			5'd7:  c = mk(1'b1, SRC_SRC,   3'd5, 1'b0, LAST_NO,  1'b0, COND_ALWAYS, 5'd8, 5'd8);
			5'd8:  c = mk(1'b1, SRC_SRC,   3'd4, 1'b0, LAST_NO,  1'b0, COND_ALWAYS, 5'd9, 5'd9);
			5'd9:  c = mk(1'b1, SRC_SRC,   3'd3, 1'b0, LAST_NO,  1'b0, COND_ALWAYS, 5'd10, 5'd10);
			5'd10: c = mk(1'b1, SRC_SRC,   3'd2, 1'b0, LAST_NO,  1'b0, COND_ALWAYS, 5'd11, 5'd11);
			5'd11: c = mk(1'b1, SRC_SRC,   3'd1, 1'b0, LAST_NO,  1'b0, COND_ALWAYS, 5'd12, 5'd12);
			5'd12: c = mk(1'b1, SRC_SRC,   3'd0, 1'b0, LAST_NO,  1'b0, COND_ALWAYS, 5'd13, 5'd13);
			5'd13: c = mk(1'b1, SRC_INNER, 3'd0, 1'b0, LAST_NO,  1'b0, COND_ALWAYS, 5'd14, 5'd14);
			5'd14: c = mk(1'b1, SRC_INNER, 3'd1, 1'b0, LAST_NO,  1'b0, COND_ALWAYS, 5'd15, 5'd15);
			5'd15: c = mk(1'b1, SRC_START, 3'd1, 1'b0, LAST_NO,  1'b0, COND_ALWAYS, 5'd16, 5'd16);
			5'd16: c = mk(1'b1, SRC_START, 3'd0, 1'b0, LAST_NO,  1'b0, COND_ALWAYS, 5'd17, 5'd17);
			5'd17: c = mk(1'b1, SRC_ID,    3'd1, 1'b1, LAST_NO,  1'b0, COND_ALWAYS, 5'd18, 5'd18);
			5'd18: c = mk(1'b1, SRC_ID,    3'd0, 1'b1, LAST_NO,  1'b0, COND_ALWAYS, 5'd19, 5'd19);
			5'd19: c = mk(1'b1, SRC_LEN,   3'd0, 1'b1, LAST_NO,  1'b0, COND_ALWAYS, 5'd20, 5'd20);
			5'd20: c = mk(1'b1, SRC_LEN,   3'd1, 1'b1, LAST_NO,  1'b0, COND_ALWAYS, 5'd21, 5'd21);
			5'd21: c = mk(1'b1, SRC_ZERO,  3'd0, 1'b1, LAST_NO,  1'b0, COND_ALWAYS, 5'd22, 5'd22);
			5'd22: c = mk(1'b1, SRC_ZERO,  3'd0, 1'b1, LAST_NO,  1'b0, COND_LEFT_NZ,
				STEP_HOME, STEP_TRAILER);
			5'd23: c = mk(1'b1, SRC_CRC,   3'd1, 1'b0, LAST_NO,  1'b1, COND_ALWAYS, 5'd24, 5'd24);
			5'd24: c = mk(1'b1, SRC_CRC,   3'd0, 1'b0, LAST_CRC, 1'b0, COND_PAD_ZERO,
				STEP_HOME, STEP_PAD);
			5'd25: c = mk(1'b1, SRC_ZERO,  3'd0, 1'b0, LAST_PAD, 1'b0, COND_PAD_MORE,
				STEP_PAD, STEP_HOME);
			default: c = mk(1'b0, SRC_ZERO, 3'd0, 1'b0, LAST_NO, 1'b0, COND_ALWAYS,
				STEP_HOME, STEP_HOME);
		endcase
		return c;
	endfunction

endpackage

/* rtl/core/ecf_sequencer.sv */
// Step counter and microcode table lookup of the Ethernet command framer.
// Depends on ecf_pkg for the control word layout and the program.
`timescale 1ns / 1ps

module ecf_sequencer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  ecf_pkg::seq_stat_t stat,
	output ecf_pkg::ctrl_t    ctrl,
	output logic              at_home
);

	ecf_pkg::step_t pc_q;
	ecf_pkg::step_t pc_next;
	logic           taken;

	assign ctrl    = ecf_pkg::ucode(pc_q);
	assign at_home = (pc_q == ecf_pkg::STEP_HOME);

	always_comb begin
		taken   = 1'b1;
		pc_next = ctrl.tgt_t;
		unique case (ctrl.cond)
			ecf_pkg::COND_ALWAYS:   taken = 1'b1;
			ecf_pkg::COND_LEFT_NZ:  taken = stat.left_nz;
			ecf_pkg::COND_PAD_ZERO: taken = stat.pad_zero;
			ecf_pkg::COND_PAD_MORE: taken = stat.pad_more;
			ecf_pkg::COND_DISPATCH: taken = stat.hdr;
			default:                taken = 1'b1;
		endcase
		if (taken) begin
			pc_next = ctrl.tgt_t;
		end else if (ctrl.cond == ecf_pkg::COND_DISPATCH && stat.pay_end) begin
			// The last payload byte leads straight into the trailer.
			pc_next = ecf_pkg::STEP_TRAILER;
		end else begin
			pc_next = ctrl.tgt_f;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ecf_pkg::STEP_HOME;
		end else if (go) begin
			pc_q <= pc_next;
		end
	end

endmodule

/* rtl/core/ethernet_command_framer_crc16_core.sv */
// Top level of the Ethernet command framer: input holding register, datapath,
// configuration registers and output register. Depends on ecf_pkg and ecf_sequencer.
`timescale 1ns / 1ps

// Usage
// The input channel (in_valid/in_ready) takes items: mode 0 is a header with
// msg_id and pay_len, mode 1 carries one payload byte in data_byte.
// The output channel (out_valid/out_ready) gives the frame one byte per item in
// out_byte, with frame_last high on the final byte. The configuration channel
// (cfg_valid/cfg_ready, always ready) writes dest_mac, src_mac, start_word and
// min_payload_bytes by cfg_index; the user must see that it is used only while
// the block is idle, as the block itself does not enforce this. An accepted item
// sits in a one-entry holding register and is taken by the microcode sequencer in
// the next cycle at the earliest. While out_ready is high, a header produces 22
// bytes, one per cycle, plus the trailer when its length is zero, and payload
// streams at one byte per cycle; after the last one the trailer of two CRC bytes
// and any zero padding follows at the same rate, which is set by the single
// output register that the sequencer fills once per step. A payload byte passes
// through the holding and output registers, the first byte of a header also
// through the step counter. Reset clears the sequencer, the holding and output
// valid flags and restores the register defaults. While a byte waits with
// out_ready low the sequencer halts, the holding register fills, then in_ready drops.

module ethernet_command_framer_crc16_core #(
	parameter int unsigned PAYLOAD_LEN_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        mode,
	input  logic [15:0] msg_id,
	input  logic [15:0] pay_len,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        frame_last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [47:0] cfg_data
);

	localparam int unsigned LW = PAYLOAD_LEN_BITS;

	logic [ecf_pkg::MAC_W-1:0]   dest_mac_q;
	logic [ecf_pkg::MAC_W-1:0]   src_mac_q;
	logic [15:0]                 start_word_q;
	logic [ecf_pkg::MINSZ_W-1:0] min_bytes_q;

	logic        hold_valid_q;
	logic        hold_mode_q;
	logic [15:0] hold_id_q;
	logic [LW-1:0] hold_len_q;
	logic [7:0]  hold_data_q;

	logic [15:0]   id_q;
	logic [LW-1:0] len_q;
	logic [LW-1:0] left_q;
	logic          open_q;
	logic [5:0]    pad_q;
	logic [15:0]   crc_q;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       frame_last_q;

	ecf_pkg::ctrl_t    ctrl;
	ecf_pkg::seq_stat_t stat;
	logic       at_home;
	logic       out_free;
	logic       go;
	logic       consume;
	logic       do_hdr;
	logic       do_pay;
	logic       emit;
	logic       in_accept;
	logic [15:0] len16;
	logic [15:0] hold_len16;
	logic [15:0] inner;
	logic [16:0] hold_sum;
	logic [5:0]  minsz;
	logic [15:0] src_word;
	logic [47:0] wide_word;
	logic [7:0]  byte_sel;
	logic        last_sel;

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign frame_last = frame_last_q;

	assign out_free  = !out_valid_q || out_ready;
	assign consume   = at_home && hold_valid_q && out_free;
	assign go        = at_home ? consume : out_free;
	assign in_ready  = !hold_valid_q || consume;
	assign in_accept = in_valid && in_ready;

	assign do_hdr = consume && (hold_mode_q == ecf_pkg::MODE_HEADER);
	assign do_pay = consume && (hold_mode_q == ecf_pkg::MODE_PAYLOAD) && open_q &&
		(left_q != '0);
	assign emit   = at_home ? do_pay : (go && ctrl.emit);

	assign stat.hdr      = do_hdr;
	assign stat.pay_end  = do_pay && (left_q == LW'(1));
	assign stat.left_nz  = (left_q != '0);
	assign stat.pad_zero = (pad_q == 6'd0);
	assign stat.pad_more = (pad_q > 6'd1);

	assign len16      = ecf_pkg::LEN_W'(len_q);
	assign hold_len16 = ecf_pkg::LEN_W'(hold_len_q);
	assign inner      = len16 + 16'(ecf_pkg::INNER_OVHD);
	assign hold_sum   = {1'b0, hold_len16} + 17'(ecf_pkg::INNER_OVHD);
	assign minsz      = (min_bytes_q > ecf_pkg::PAD_CAP) ? ecf_pkg::PAD_CAP : min_bytes_q;

	ecf_sequencer u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (go),
		.stat    (stat),
		.ctrl    (ctrl),
		.at_home (at_home)
	);

	// Byte selection: the MAC sources pick one of six bytes, the rest one of two.
	always_comb begin
		src_word  = 16'h0000;
		wide_word = '0;
		unique case (ctrl.src)
			ecf_pkg::SRC_ZERO:  src_word = 16'h0000;
			ecf_pkg::SRC_DEST:  wide_word = dest_mac_q;
			ecf_pkg::SRC_SRC:   wide_word = src_mac_q;
			ecf_pkg::SRC_INNER: src_word = inner;
			ecf_pkg::SRC_START: src_word = start_word_q;
			ecf_pkg::SRC_ID:    src_word = id_q;
			ecf_pkg::SRC_LEN:   src_word = len16;
			ecf_pkg::SRC_DATA:  src_word = {8'h00, hold_data_q};
			ecf_pkg::SRC_CRC:   src_word = crc_q;
			default:            src_word = 16'h0000;
		endcase
		if (ctrl.src == ecf_pkg::SRC_DEST || ctrl.src == ecf_pkg::SRC_SRC) begin
			unique case (ctrl.sel)
				3'd0:    byte_sel = wide_word[7:0];
				3'd1:    byte_sel = wide_word[15:8];
				3'd2:    byte_sel = wide_word[23:16];
				3'd3:    byte_sel = wide_word[31:24];
				3'd4:    byte_sel = wide_word[39:32];
				3'd5:    byte_sel = wide_word[47:40];
				default: byte_sel = 8'h00;
			endcase
		end else begin
			byte_sel = ctrl.sel[0] ? src_word[15:8] : src_word[7:0];
		end
	end

	always_comb begin
		unique case (ctrl.last)
			ecf_pkg::LAST_NO:  last_sel = 1'b0;
			ecf_pkg::LAST_CRC: last_sel = (pad_q == 6'd0);
			ecf_pkg::LAST_PAD: last_sel = (pad_q == 6'd1);
			default:           last_sel = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_mac_q   <= '0;
			src_mac_q    <= '0;
			start_word_q <= 16'h0000;
			min_bytes_q  <= ecf_pkg::PAD_CAP;
		end else if (cfg_valid) begin
			unique case (ecf_pkg::reg_idx_t'(cfg_index))
				ecf_pkg::REG_DEST_MAC:  dest_mac_q   <= cfg_data;
				ecf_pkg::REG_SRC_MAC:   src_mac_q    <= cfg_data;
				ecf_pkg::REG_START:     start_word_q <= cfg_data[15:0];
				ecf_pkg::REG_MIN_BYTES: min_bytes_q  <= cfg_data[ecf_pkg::MINSZ_W-1:0];
				default:                min_bytes_q  <= min_bytes_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
		end else if (in_accept) begin
			hold_valid_q <= 1'b1;
		end else if (consume) begin
			hold_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			hold_mode_q <= mode;
			hold_id_q   <= msg_id;
			hold_len_q  <= pay_len[LW-1:0];
			hold_data_q <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			left_q <= '0;
			pad_q  <= 6'd0;
			crc_q  <= ecf_pkg::CRC_INIT;
		end else if (do_hdr) begin
			// A header always restarts the frame, open or not.
			open_q <= 1'b1;
			left_q <= hold_len_q;
			pad_q  <= (hold_sum < 17'(minsz)) ? (minsz - hold_sum[5:0]) : 6'd0;
			crc_q  <= ecf_pkg::CRC_INIT;
		end else if (emit) begin
			if (ctrl.crc_en) begin
				crc_q <= ecf_pkg::crc16_byte(crc_q, byte_sel);
			end
			if (do_pay) begin
				left_q <= left_q - LW'(1);
			end
			if (ctrl.close) begin
				open_q <= 1'b0;
			end
			if (ctrl.last == ecf_pkg::LAST_PAD) begin
				pad_q <= pad_q - 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_hdr) begin
			id_q  <= hold_id_q;
			len_q <= hold_len_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q   <= byte_sel;
			frame_last_q <= last_sel;
		end
	end

endmodule
